[sv/dnsae_pkg.sv]
// Shared types and constants of the DNS response address extractor.
package dnsae_pkg;

   localparam int MaxDatagramDefault = 256;

   localparam logic [3:0] HdrLast = 4'd11;
   localparam logic [3:0] HdrLen  = 4'd12;
   localparam logic [7:0] PtrMask = 8'hC0;
   localparam logic [15:0] ACode  = 16'h0001;
   localparam logic [15:0] ALen   = 16'h0004;

   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_TOO_SHORT   = 3'd1;
   localparam logic [2:0] ST_ID_MISMATCH = 3'd2;
   localparam logic [2:0] ST_NOT_RESP    = 3'd3;
   localparam logic [2:0] ST_TRUNCATED   = 3'd4;
   localparam logic [2:0] ST_TC_MISMATCH = 3'd5;

   localparam logic KIND_ADDR   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   typedef enum logic [12:0] {
      PH_HEADER     = 13'b0000000000001,
      PH_QNAME      = 13'b0000000000010,
      PH_QTYPE      = 13'b0000000000100,
      PH_QCLASS     = 13'b0000000001000,
      PH_NAME_FIRST = 13'b0000000010000,
      PH_NAME_REST  = 13'b0000000100000,
      PH_PTR        = 13'b0000001000000,
      PH_ATYPE      = 13'b0000010000000,
      PH_ACLASS     = 13'b0000100000000,
      PH_TTL        = 13'b0001000000000,
      PH_RDLEN      = 13'b0010000000000,
      PH_RDATA_A    = 13'b0100000000000,
      PH_RDATA_SKIP = 13'b1000000000000
   } phase_type;

   typedef struct packed {
      logic        kind;
      logic [31:0] address;
      logic [2:0]  status;
      logic        last;
   } result_type;

endpackage

[sv/dns_response_address_extractor_unit.sv]
// Top level: byte-serial DNS response parser that emits A-record addresses and a status word.
// A result is registered into the result queue when the byte that causes it is accepted.
// Throughput: one byte per cycle while req_tready is high; each byte is parsed in the cycle it is accepted.
// Results pass through a four-word queue; req_tready stays high while two words are free,
// so a byte yielding an address and a status at once always finds room for both words.
// Reset (synchronous): parser returns to the header phase, expected_id and queue clear.
module dns_response_address_extractor_unit
   import dnsae_pkg::*;
#(
   parameter int MAX_DATAGRAM = MaxDatagramDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // end_of_datagram
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] address, [34:32] status, [39:35] zero
   output logic        rsp_tuser,   // kind
   output logic        rsp_tlast,   // last_of_run
   input  logic        csr_we,
   input  logic [15:0] csr_wdata    // expected_id
);

   localparam int PosW = $clog2(MAX_DATAGRAM + 1);
   localparam logic [PosW-1:0] PosMax = PosW'(MAX_DATAGRAM);

   logic [15:0]     expected_id_ff;
   phase_type       phase_ff, phase_in;
   logic [PosW-1:0] pos_ff, pos_in;
   logic [15:0]     fc_ff, fc_in;
   logic [15:0]     qtype_ff, qtype_in;
   logic [15:0]     qclass_ff, qclass_in;
   logic [15:0]     atype_ff, atype_in;
   logic [15:0]     aclass_ff, aclass_in;
   logic [15:0]     dlen_ff, dlen_in;
   logic [31:0]     acc_ff, acc_in;
   logic [2:0]      pend_ff, pend_in;
   logic            stopped_ff, stopped_in;

   result_type      q_ff [4];
   logic [1:0]      wr_ff, rd_ff;
   logic [2:0]      cnt_ff;

   logic            accept, counted, addr_hit, pop;
   logic [7:0]      b;
   logic [15:0]     fc_inc;
   logic [2:0]      st;
   logic [1:0]      nres;
   result_type      e0, e1;

   assign b       = req_tdata;
   assign accept  = req_tvalid && req_tready;
   assign counted = accept && (pos_ff < PosMax);
   assign fc_inc  = fc_ff + 16'd1;

   always_comb begin
      phase_in   = phase_ff;
      pos_in     = pos_ff + PosW'(counted);
      fc_in      = fc_ff;
      qtype_in   = qtype_ff;
      qclass_in  = qclass_ff;
      atype_in   = atype_ff;
      aclass_in  = aclass_ff;
      dlen_in    = dlen_ff;
      acc_in     = acc_ff;
      pend_in    = pend_ff;
      stopped_in = stopped_ff;
      addr_hit   = 1'b0;
      if (counted && !stopped_ff) begin
         unique case (phase_ff)
            PH_HEADER: begin
               if (pos_ff == PosW'(0)) begin
                  fc_in = {8'd0, b};
               end else if (pos_ff == PosW'(1)) begin
                  if ({fc_ff[7:0], b} != expected_id_ff) begin
                     stopped_in = 1'b1;
                     pend_in    = ST_ID_MISMATCH;
                  end
               end else if (pos_ff == PosW'(2)) begin
                  if (!b[7]) begin
                     stopped_in = 1'b1;
                     pend_in    = ST_NOT_RESP;
                  end
               end
               if (pos_ff == PosW'(HdrLast)) begin
                  phase_in = PH_QNAME;
                  fc_in    = '0;
               end
            end
            PH_QNAME: begin
               if (b == 8'd0) begin
                  phase_in = PH_QTYPE;
                  fc_in    = '0;
               end
            end
            PH_QTYPE: begin
               qtype_in = {qtype_ff[7:0], b};
               fc_in    = fc_inc;
               if (fc_inc == 16'd2) begin
                  phase_in = PH_QCLASS;
                  fc_in    = '0;
               end
            end
            PH_QCLASS: begin
               qclass_in = {qclass_ff[7:0], b};
               fc_in     = fc_inc;
               if (fc_inc == 16'd2) begin
                  phase_in = PH_NAME_FIRST;
                  fc_in    = '0;
               end
            end
            PH_NAME_FIRST: begin
               if ((b & PtrMask) == PtrMask) begin
                  phase_in = PH_PTR;
               end else if (b == 8'd0) begin
                  phase_in = PH_ATYPE;
                  fc_in    = '0;
               end else begin
                  phase_in = PH_NAME_REST;
               end
            end
            PH_NAME_REST: begin
               if (b == 8'd0) begin
                  phase_in = PH_ATYPE;
                  fc_in    = '0;
               end
            end
            PH_PTR: begin
               phase_in = PH_ATYPE;
               fc_in    = '0;
            end
            PH_ATYPE: begin
               atype_in = {atype_ff[7:0], b};
               fc_in    = fc_inc;
               if (fc_inc == 16'd2) begin
                  phase_in = PH_ACLASS;
                  fc_in    = '0;
               end
            end
            PH_ACLASS: begin
               aclass_in = {aclass_ff[7:0], b};
               fc_in     = fc_inc;
               if (fc_inc == 16'd2) begin
                  fc_in = '0;
                  if (atype_ff != qtype_ff || {aclass_ff[7:0], b} != qclass_ff) begin
                     stopped_in = 1'b1;
                     pend_in    = ST_TC_MISMATCH;
                  end else begin
                     phase_in = PH_TTL;
                  end
               end
            end
            PH_TTL: begin
               fc_in = fc_inc;
               if (fc_inc == 16'd4) begin
                  phase_in = PH_RDLEN;
                  fc_in    = '0;
               end
            end
            PH_RDLEN: begin
               dlen_in = {dlen_ff[7:0], b};
               fc_in   = fc_inc;
               if (fc_inc == 16'd2) begin
                  if (atype_ff == ACode && aclass_ff == ACode && dlen_in == ALen) begin
                     phase_in = PH_RDATA_A;
                     fc_in    = '0;
                     acc_in   = '0;
                  end else if (dlen_in == 16'd0) begin
                     phase_in = PH_NAME_FIRST;
                     fc_in    = '0;
                  end else begin
                     phase_in = PH_RDATA_SKIP;
                     fc_in    = dlen_in;
                  end
               end
            end
            PH_RDATA_A: begin
               acc_in = {acc_ff[23:0], b};
               fc_in  = fc_inc;
               if (fc_inc == ALen) begin
                  phase_in = PH_NAME_FIRST;
                  fc_in    = '0;
                  addr_hit = 1'b1;
               end
            end
            PH_RDATA_SKIP: begin
               fc_in = fc_ff - 16'd1;
               if (fc_in == 16'd0) begin
                  phase_in = PH_NAME_FIRST;
               end
            end
            default: begin
               phase_in = PH_HEADER;
            end
         endcase
      end

      if (pos_in <= PosW'(HdrLen)) begin
         st = ST_TOO_SHORT;
      end else if (stopped_in) begin
         st = pend_in;
      end else if (phase_in != PH_NAME_FIRST) begin
         st = ST_TRUNCATED;
      end else begin
         st = ST_OK;
      end

      e0 = '{kind: KIND_STATUS, address: 32'd0, status: st, last: 1'b1};
      e1 = e0;
      nres = '0;
      if (accept) begin
         if (addr_hit) begin
            e0   = '{kind: KIND_ADDR, address: acc_in, status: ST_OK, last: !req_tlast};
            nres = req_tlast ? 2'd2 : 2'd1;
         end else if (req_tlast) begin
            nres = 2'd1;
         end
      end

      if (accept && req_tlast) begin
         phase_in   = PH_HEADER;
         pos_in     = '0;
         fc_in      = '0;
         qtype_in   = '0;
         qclass_in  = '0;
         atype_in   = '0;
         aclass_in  = '0;
         dlen_in    = '0;
         acc_in     = '0;
         pend_in    = ST_OK;
         stopped_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_id_ff <= '0;
         phase_ff       <= PH_HEADER;
         pos_ff         <= '0;
         fc_ff          <= '0;
         qtype_ff       <= '0;
         qclass_ff      <= '0;
         atype_ff       <= '0;
         aclass_ff      <= '0;
         dlen_ff        <= '0;
         acc_ff         <= '0;
         pend_ff        <= ST_OK;
         stopped_ff     <= 1'b0;
      end else begin
         if (csr_we) begin
            expected_id_ff <= csr_wdata;
         end
         phase_ff   <= phase_in;
         pos_ff     <= pos_in;
         fc_ff      <= fc_in;
         qtype_ff   <= qtype_in;
         qclass_ff  <= qclass_in;
         atype_ff   <= atype_in;
         aclass_ff  <= aclass_in;
         dlen_ff    <= dlen_in;
         acc_ff     <= acc_in;
         pend_ff    <= pend_in;
         stopped_ff <= stopped_in;
      end
   end

   // result queue
   assign pop        = rsp_tvalid && rsp_tready;
   assign req_tready = cnt_ff <= 3'd2;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_ff + nres;
         rd_ff  <= rd_ff + 2'(pop);
         cnt_ff <= cnt_ff + 3'(nres) - 3'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (nres != 2'd0) begin
         q_ff[wr_ff] <= e0;
      end
      if (nres == 2'd2) begin
         q_ff[wr_ff + 2'd1] <= e1;
      end
   end

   assign rsp_tvalid = cnt_ff != 3'd0;
   assign rsp_tdata  = {5'd0, q_ff[rd_ff].status, q_ff[rd_ff].address};
   assign rsp_tuser  = q_ff[rd_ff].kind;
   assign rsp_tlast  = q_ff[rd_ff].last;

endmodule

[sv/dnsae_checker.sv]
// Port-level checker for the DNS response address extractor, bound to the top level.
module dnsae_checker
   import dnsae_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp word changed while stalled");

   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_STATUS |-> rsp_tlast && rsp_tdata[31:0] == 32'd0)
      else $error("status word not last or carries an address");

   a_addr_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_ADDR |-> rsp_tdata[34:32] == ST_OK)
      else $error("address word carries a status");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[39:35] == 5'd0 && rsp_tdata[34:32] <= ST_TC_MISMATCH)
      else $error("status out of range or padding set");

endmodule

bind dns_response_address_extractor_unit dnsae_checker u_dnsae_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

[verif/tb_dns_response_address_extractor_unit.sv]
// Testbench: streams random and directed DNS responses through the extractor and checks every word.
`timescale 1ns / 1ps

module tb_dns_response_address_extractor_unit;
   import dnsae_pkg::*;

   localparam int CycleLimit = 400000;
   localparam int LongHold   = 300;
   localparam int PhaseBytes = 390;

   class dns_reply_scoreboard;
      logic [15:0] awaited_id;
      phase_type   parse_phase;
      logic [8:0]  offset;
      logic [15:0] count;
      logic [15:0] qtype_seen;
      logic [15:0] qclass_seen;
      logic [15:0] rr_type;
      logic [15:0] rr_class;
      logic [15:0] rdata_len;
      logic [31:0] addr_acc;
      logic [2:0]  halt_status;
      logic        halted;
      result_type  expected_words[$];
      int          mismatches;
      int          words_checked;

      function new();
         awaited_id    = '0;
         mismatches    = 0;
         words_checked = 0;
         restart();
      endfunction

      function void restart();
         parse_phase = PH_HEADER;
         offset      = '0;
         count       = '0;
         qtype_seen  = '0;
         qclass_seen = '0;
         rr_type     = '0;
         rr_class    = '0;
         rdata_len   = '0;
         addr_acc    = '0;
         halt_status = ST_OK;
         halted      = 1'b0;
      endfunction

      function void halt(logic [2:0] code);
         halted      = 1'b1;
         halt_status = code;
      endfunction

      // advance the parser by one counted byte; return 1 when an address completes
      function bit parse_byte(logic [7:0] b, logic [8:0] p);
         bit addr_done;
         addr_done = 1'b0;
         case (parse_phase)
            PH_HEADER: begin
               if (p == 0) begin
                  count = {8'h00, b};
               end else if (p == 1) begin
                  if ({count[7:0], b} != awaited_id) halt(ST_ID_MISMATCH);
               end else if (p == 2) begin
                  if (!b[7]) halt(ST_NOT_RESP);
               end
               if (p == HdrLast) begin
                  parse_phase = PH_QNAME;
                  count = '0;
               end
            end
            PH_QNAME: begin
               if (b == 8'h00) begin
                  parse_phase = PH_QTYPE;
                  count = '0;
               end
            end
            PH_QTYPE: begin
               qtype_seen = {qtype_seen[7:0], b};
               count++;
               if (count == 2) begin
                  parse_phase = PH_QCLASS;
                  count = '0;
               end
            end
            PH_QCLASS: begin
               qclass_seen = {qclass_seen[7:0], b};
               count++;
               if (count == 2) begin
                  parse_phase = PH_NAME_FIRST;
                  count = '0;
               end
            end
            PH_NAME_FIRST: begin
               if ((b & PtrMask) == PtrMask) begin
                  parse_phase = PH_PTR;
               end else if (b == 8'h00) begin
                  parse_phase = PH_ATYPE;
                  count = '0;
               end else begin
                  parse_phase = PH_NAME_REST;
               end
            end
            PH_NAME_REST: begin
               if (b == 8'h00) begin
                  parse_phase = PH_ATYPE;
                  count = '0;
               end
            end
            PH_PTR: begin
               parse_phase = PH_ATYPE;
               count = '0;
            end
            PH_ATYPE: begin
               rr_type = {rr_type[7:0], b};
               count++;
               if (count == 2) begin
                  parse_phase = PH_ACLASS;
                  count = '0;
               end
            end
            PH_ACLASS: begin
               rr_class = {rr_class[7:0], b};
               count++;
               if (count == 2) begin
                  count = '0;
                  if (rr_type != qtype_seen || rr_class != qclass_seen) halt(ST_TC_MISMATCH);
                  else parse_phase = PH_TTL;
               end
            end
            PH_TTL: begin
               count++;
               if (count == 4) begin
                  parse_phase = PH_RDLEN;
                  count = '0;
               end
            end
            PH_RDLEN: begin
               rdata_len = {rdata_len[7:0], b};
               count++;
               if (count == 2) begin
                  if (rr_type == ACode && rr_class == ACode && rdata_len == ALen) begin
                     parse_phase = PH_RDATA_A;
                     count = '0;
                     addr_acc = '0;
                  end else if (rdata_len == 0) begin
                     parse_phase = PH_NAME_FIRST;
                     count = '0;
                  end else begin
                     parse_phase = PH_RDATA_SKIP;
                     count = rdata_len;
                  end
               end
            end
            PH_RDATA_A: begin
               addr_acc = {addr_acc[23:0], b};
               count++;
               if (count == ALen) begin
                  parse_phase = PH_NAME_FIRST;
                  count = '0;
                  addr_done = 1'b1;
               end
            end
            PH_RDATA_SKIP: begin
               count--;
               if (count == 0) parse_phase = PH_NAME_FIRST;
            end
            default: parse_phase = PH_HEADER;
         endcase
         return addr_done;
      endfunction

      function void note_byte(logic [7:0] b, logic eod);
         result_type w;
         logic [8:0] p;
         if (offset < MaxDatagramDefault) begin
            p = offset;
            offset++;
            if (!halted && parse_byte(b, p)) begin
               w.kind    = KIND_ADDR;
               w.address = addr_acc;
               w.status  = ST_OK;
               w.last    = !eod;
               expected_words.push_back(w);
            end
         end
         if (eod) begin
            w.kind    = KIND_STATUS;
            w.address = '0;
            w.last    = 1'b1;
            if (offset <= HdrLen) w.status = ST_TOO_SHORT;
            else if (halted) w.status = halt_status;
            else if (parse_phase != PH_NAME_FIRST) w.status = ST_TRUNCATED;
            else w.status = ST_OK;
            expected_words.push_back(w);
            restart();
         end
      endfunction

      function int pending();
         return expected_words.size();
      endfunction

      task report(string msg);
         mismatches++;
         if (mismatches <= 40) $display("ERROR: %s", msg);
      endtask

      task check_word(logic kind, logic [39:0] data, logic last);
         result_type want;
         words_checked++;
         if (expected_words.size() == 0) begin
            report($sformatf("unexpected word kind=%0b data=%h last=%0b", kind, data, last));
            return;
         end
         want = expected_words.pop_front();
         if (kind !== want.kind)
            report($sformatf("kind %0b, want %0b", kind, want.kind));
         if (data[31:0] !== want.address)
            report($sformatf("address %h, want %h", data[31:0], want.address));
         if (data[34:32] !== want.status)
            report($sformatf("status %0d, want %0d", data[34:32], want.status));
         if (data[39:35] !== 5'b0)
            report($sformatf("pad bits %b not zero", data[39:35]));
         if (last !== want.last)
            report($sformatf("last %0b, want %0b", last, want.last));
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] data_byte
   logic        req_tlast;   // end_of_datagram
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;   // [31:0] address, [34:32] status, [39:35] zero
   logic        rsp_tuser;   // kind
   logic        rsp_tlast;   // last_of_run
   logic        csr_we;
   logic [15:0] csr_wdata;   // expected_id

   dns_reply_scoreboard board = new();
   logic [7:0]  dg[$];
   int          burst_left = 0;
   int          bytes_sent = 0;
   int unsigned cycles = 0;

   dns_response_address_extractor_unit #(
      .MAX_DATAGRAM(MaxDatagramDefault)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
   end

   initial begin
      wait (cycles >= CycleLimit);
      $display("FAILURE");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_word(rsp_tuser, rsp_tdata, rsp_tlast);
   end

   // receiver: changing stall patterns, plus two long hold-offs to back up the block
   initial begin
      int mode;
      int mode_left;
      int holds_done;
      int hold_marks[2];
      rsp_tready = 1'b0;
      mode = 0;
      mode_left = 0;
      holds_done = 0;
      hold_marks = '{20, 90};
      forever begin
         @(negedge clock);
         if (holds_done < 2 && board.words_checked >= hold_marks[holds_done]) begin
            rsp_tready = 1'b0;
            repeat (LongHold) @(negedge clock);
            holds_done++;
         end
         if (mode_left == 0) begin
            mode = $urandom_range(0, 3);
            mode_left = $urandom_range(32, 256);
         end
         mode_left--;
         case (mode)
            0: rsp_tready = 1'b1;
            1: rsp_tready = $urandom_range(0, 1);
            2: rsp_tready = ($urandom_range(0, 3) == 0);
            default: rsp_tready = ((mode_left % 8) < 5);
         endcase
      end
   end

   task automatic push16(logic [15:0] v);
      dg.push_back(v[15:8]);
      dg.push_back(v[7:0]);
   endtask

   // offer each byte of dg in bursts with random gaps; return at a falling edge
   task automatic send_datagram();
      for (int i = 0; i < dg.size(); i++) begin
         if (burst_left == 0) begin
            req_tvalid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
         end
         burst_left--;
         req_tvalid = 1'b1;
         req_tdata  = dg[i];
         req_tlast  = (i == dg.size() - 1);
         do @(posedge clock); while (!req_tready);
         board.note_byte(dg[i], req_tlast);
         bytes_sent++;
         @(negedge clock);
      end
   endtask

   initial begin
      logic [15:0] phase_ids[5];
      logic [15:0] id;
      logic [15:0] qt;
      logic [15:0] qc;
      logic [15:0] at;
      logic [15:0] ac;
      logic [15:0] rdlen;
      int unsigned pick;
      int unsigned k;
      int unsigned n_ans;
      bit ran_out;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      csr_we     = 1'b0;
      csr_wdata  = '0;
      phase_ids  = '{16'h0000, 16'hFFFF, 16'($urandom), 16'h8001, 16'($urandom)};
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int ph = 0; ph < 5; ph++) begin
         id = phase_ids[ph];
         csr_we    = 1'b1;
         csr_wdata = id;
         @(posedge clock);
         board.awaited_id = id;
         @(negedge clock);
         csr_we = 1'b0;

         if (ph == 0) begin
            // lone byte, a full header with nothing after it, a non-response
            dg = '{8'hFF};
            send_datagram();
            dg = '{8'h00, 8'h00, 8'h80, 8'h00, 8'h00, 8'h00,
                   8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
            send_datagram();
            dg = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                   8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
            send_datagram();
         end

         while (bytes_sent < (ph + 1) * PhaseBytes) begin
            dg.delete();
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
               repeat ($urandom_range(1, 40)) dg.push_back(8'($urandom));
            end else begin
               push16((pick < 14) ? (id ^ 16'($urandom_range(1, 65535))) : id);
               dg.push_back((pick < 20) ? 8'($urandom_range(0, 127))
                                        : 8'($urandom_range(128, 255)));
               repeat (9) dg.push_back(8'($urandom));
               repeat ($urandom_range(0, 8)) dg.push_back(8'($urandom_range(1, 255)));
               dg.push_back(8'h00);
               if ($urandom_range(0, 6) == 0) begin
                  qt = 16'($urandom);
                  qc = 16'($urandom);
               end else begin
                  qt = ACode;
                  qc = ACode;
               end
               push16(qt);
               push16(qc);
               ran_out = 1'b0;
               n_ans = $urandom_range(0, 4);
               for (int a = 0; a < n_ans && !ran_out; a++) begin
                  k = $urandom_range(0, 9);
                  if (k < 5) begin
                     dg.push_back(PtrMask | 8'($urandom_range(0, 63)));
                     dg.push_back(8'($urandom));
                  end else if (k < 7) begin
                     dg.push_back(8'h00);
                  end else begin
                     dg.push_back(8'($urandom_range(1, 191)));
                     repeat ($urandom_range(0, 5)) dg.push_back(8'($urandom_range(1, 255)));
                     dg.push_back(8'h00);
                  end
                  if ($urandom_range(0, 11) == 0) begin
                     at = 16'($urandom);
                     ac = 16'($urandom);
                  end else begin
                     at = qt;
                     ac = qc;
                  end
                  push16(at);
                  push16(ac);
                  repeat (4) dg.push_back(8'($urandom));
                  k = $urandom_range(0, 99);
                  if (at == ACode && ac == ACode && k < 75) rdlen = ALen;
                  else if (k < 20) rdlen = '0;
                  else if (k < 94) rdlen = 16'($urandom_range(1, 10));
                  else if (k < 97) rdlen = 16'($urandom_range(200, 300));
                  else rdlen = 16'($urandom);
                  push16(rdlen);
                  if (rdlen > 300) begin
                     repeat ($urandom_range(0, 20)) dg.push_back(8'($urandom));
                     ran_out = 1'b1;
                  end else begin
                     repeat (rdlen) dg.push_back(8'($urandom));
                  end
               end
               if ($urandom_range(0, 6) == 0) begin
                  k = $urandom_range(1, dg.size());
                  while (dg.size() > k) void'(dg.pop_back());
               end
            end
            send_datagram();
         end

         req_tvalid = 1'b0;
         while (board.pending() != 0) @(negedge clock);
         repeat (8) @(negedge clock);
      end

      if (board.mismatches == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule

[files.f]
sv/dnsae_pkg.sv
sv/dns_response_address_extractor_unit.sv
sv/dnsae_checker.sv
verif/tb_dns_response_address_extractor_unit.sv
